// File: design/vpia_pkg.sv
// Package for the vectored priority interrupt arbiter.
// Holds slot count, field widths, event kind and configuration register codes.
// Has no dependencies; every RTL file of the block imports it.
`default_nettype none

package vpia_pkg;

  // Number of device slots that are in use, and the fixed slot count of the fields.
  localparam int NUM_DEVICES = 8;
  localparam int SLOT_CNT    = 8;

  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int PRIO_W   = 3;
  localparam int LEVEL_W  = 3;
  localparam int VEC_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Slots at or above NUM_DEVICES never take part.
  localparam logic [SLOT_CNT-1:0] SLOT_MASK = SLOT_CNT'((1 << NUM_DEVICES) - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_RAISE = 2'd0,
    KIND_LOWER = 2'd1,
    KIND_ACK   = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESENT  = 2'd0,
    CFG_LEVELS   = 2'd1,
    CFG_VEC_LOW  = 2'd2,
    CFG_VEC_HIGH = 2'd3
  } cfg_idx_t;

endpackage : vpia_pkg

`default_nettype wire

// File: design/vectored_priority_interrupt_arbiter.sv
// Top level of the vectored priority interrupt arbiter.
// Holds the configuration registers, the pending request state and the arbiter.
// Depends on vpia_pkg.
//
// Usage:
//   The input channel (in_valid, in_stall) carries one event item: raise or
//   lower the request of one device slot, or acknowledge at a processor
//   priority. The result channel (out_valid, out_stall) returns exactly one
//   item for every event: the granted vector, the grant flag, the granted slot
//   and the shared request line after the event.
//   An accepted item is captured in an input register; when it advances, the
//   pending state is updated and the result register is loaded. One item per
//   cycle is sustained while the receiver does not stall; the limit is the
//   single read-modify-write of the pending request register, which every
//   item passes through once.
//   If the receiver stalls, the result register holds its item, the input
//   register fills, and in_stall rises until the result is taken.
//   The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//   one register per handshake; it is ready whenever the input register is
//   empty. Writing the present mask drops pending requests of absent slots.
//   Synchronous reset (rst_n low) clears all configuration, all pending
//   requests and both valid flags.
`default_nettype none

module vectored_priority_interrupt_arbiter
  import vpia_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [KIND_W-1:0]     in_kind,
  input  wire logic [SLOT_W-1:0]     in_device_index,
  input  wire logic [PRIO_W-1:0]     in_cpu_priority,

  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [VEC_W-1:0]      out_granted_vector,
  output      logic                  out_granted,
  output      logic [SLOT_W-1:0]     out_granted_device,
  output      logic                  out_request_line,

  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [SLOT_CNT-1:0]         present_r, present_nxt;
  logic [SLOT_CNT*LEVEL_W-1:0] levels_r, levels_nxt;
  logic [4*VEC_W-1:0]          vec_low_r, vec_low_nxt;
  logic [4*VEC_W-1:0]          vec_high_r, vec_high_nxt;

  // Pending requests, one bit per slot.
  logic [SLOT_CNT-1:0] pend_r, pend_nxt;

  // Input register.
  logic              s1_valid_r, s1_valid_nxt;
  logic [KIND_W-1:0] s1_kind_r;
  logic [SLOT_W-1:0] s1_dev_r;
  logic [PRIO_W-1:0] s1_prio_r;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [VEC_W-1:0]  out_vec_r;
  logic              out_granted_r;
  logic [SLOT_W-1:0] out_dev_r;
  logic              out_line_r;

  logic in_take;
  logic adv;
  logic cfg_take;

  logic [SLOT_CNT-1:0]  usable;
  logic [SLOT_CNT-1:0]  eligible;
  logic [SLOT_CNT-1:0]  dev_bit;
  logic                 win_found;
  logic [SLOT_W-1:0]    win_idx;
  logic [LEVEL_W-1:0]   win_level;
  logic [LEVEL_W-1:0]   slot_level;
  logic [8*VEC_W-1:0]   all_vectors;
  logic [SLOT_CNT-1:0]  pend_step;
  logic                 grant;
  logic [VEC_W-1:0]     res_vec;
  logic [SLOT_W-1:0]    res_dev;

  // The stage advances when it holds an item and the result register is empty or being emptied.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Configuration is only taken while no item sits in the input register.
  assign cfg_ready = !s1_valid_r;
  assign cfg_take  = cfg_valid && cfg_ready;

  assign usable      = present_r & SLOT_MASK;
  assign eligible    = pend_r & usable;
  assign dev_bit     = SLOT_CNT'(1) << s1_dev_r;
  assign all_vectors = {vec_high_r, vec_low_r};

  // Highest level strictly above the processor priority wins; scanning from
  // slot zero with a strict compare makes the lowest slot win a tie.
  always_comb begin
    win_found  = 1'b0;
    win_idx    = '0;
    win_level  = '0;
    slot_level = '0;
    for (int i = 0; i < SLOT_CNT; i++) begin
      slot_level = levels_r[LEVEL_W*i +: LEVEL_W];
      if (eligible[i] && (slot_level > s1_prio_r) &&
          (!win_found || (slot_level > win_level))) begin
        win_found = 1'b1;
        win_idx   = SLOT_W'(i);
        win_level = slot_level;
      end
    end
  end

  // Effect of the item in the input register on the pending requests.
  always_comb begin
    pend_step = pend_r;
    grant     = 1'b0;
    res_vec   = '0;
    res_dev   = '0;
    unique case (kind_t'(s1_kind_r))
      KIND_RAISE: begin
        if ((usable & dev_bit) != '0) begin
          pend_step = pend_r | dev_bit;
        end
      end
      KIND_LOWER: begin
        if ((usable & dev_bit) != '0) begin
          pend_step = pend_r & ~dev_bit;
        end
      end
      KIND_ACK: begin
        if (win_found) begin
          grant     = 1'b1;
          res_dev   = win_idx;
          res_vec   = all_vectors[VEC_W*win_idx +: VEC_W];
          pend_step = pend_r & ~(SLOT_CNT'(1) << win_idx);
        end
      end
      default: begin
        // The unused kind leaves everything as it is.
        pend_step = pend_r;
      end
    endcase
  end

  // Next values of the configuration and the pending state.
  always_comb begin
    present_nxt  = present_r;
    levels_nxt   = levels_r;
    vec_low_nxt  = vec_low_r;
    vec_high_nxt = vec_high_r;
    pend_nxt     = adv ? pend_step : pend_r;
    if (cfg_take) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PRESENT: begin
          present_nxt = cfg_data[SLOT_CNT-1:0];
          pend_nxt    = pend_r & cfg_data[SLOT_CNT-1:0] & SLOT_MASK;
        end
        CFG_LEVELS:   levels_nxt   = cfg_data[SLOT_CNT*LEVEL_W-1:0];
        CFG_VEC_LOW:  vec_low_nxt  = cfg_data;
        CFG_VEC_HIGH: vec_high_nxt = cfg_data;
        default:      present_nxt  = present_r;
      endcase
    end
  end

  assign s1_valid_nxt  = in_take ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_valid_r && out_stall);

  // Control and configuration state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      levels_r    <= '0;
      vec_low_r   <= '0;
      vec_high_r  <= '0;
      pend_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      present_r   <= present_nxt;
      levels_r    <= levels_nxt;
      vec_low_r   <= vec_low_nxt;
      vec_high_r  <= vec_high_nxt;
      pend_r      <= pend_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r <= in_kind;
      s1_dev_r  <= in_device_index;
      s1_prio_r <= in_cpu_priority;
    end
    if (adv) begin
      out_vec_r     <= res_vec;
      out_granted_r <= grant;
      out_dev_r     <= res_dev;
      out_line_r    <= |pend_step;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted_vector = out_vec_r;
  assign out_granted        = out_granted_r;
  assign out_granted_device = out_dev_r;
  assign out_request_line   = out_line_r;

`ifndef NO_ASSERTIONS
  // A result without a grant carries neither a vector nor a slot.
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_granted_r) |-> (out_vec_r == '0 && out_dev_r == '0))
    else $error("result without grant carries a vector or slot");

  // The granted slot no longer has a pending request afterwards.
  a_grant_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && grant) |=> !pend_r[$past(win_idx)])
    else $error("granted request still pending");

  // The reported request line matches the pending state it was taken from.
  a_line_matches: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_line_r == (|pend_r)))
    else $error("request line disagrees with pending state");

  // Absent slots never hold a pending request.
  a_absent_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & ~usable) == '0)
    else $error("pending request on an absent slot");

  // A grant always goes to a slot that was pending and above the priority.
  a_grant_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && grant) |-> (eligible[win_idx] &&
                        (levels_r[LEVEL_W*win_idx +: LEVEL_W] > s1_prio_r)))
    else $error("grant to a slot that does not qualify");
`endif

endmodule : vectored_priority_interrupt_arbiter

`default_nettype wire
